// ===== rtl/msag_pkg.sv =====
package msag_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INL_NORM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INL_REC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAT_NORM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAT_REC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EPI_NORM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EPI_REC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd7;

    typedef logic [2:0] t_reason;

    localparam t_reason REASON_OK       = 3'd0;
    localparam t_reason REASON_COUNT    = 3'd1;
    localparam t_reason REASON_RATIO    = 3'd2;
    localparam t_reason REASON_EPI      = 3'd3;
    localparam t_reason REASON_FLIP     = 3'd4;
    localparam t_reason REASON_LARGE    = 3'd5;
    localparam t_reason REASON_COOLDOWN = 3'd6;
    localparam t_reason REASON_RECOVERY = 3'd7;

    // angles in 1/256 degree
    localparam logic [15:0] MED_FALLBACK = 16'd256;
    localparam logic [15:0] MED_FLOOR    = 16'd38;
    localparam logic [15:0] LARGE_MIN    = 16'd3072;
    localparam logic [15:0] LARGE_ADD    = 16'd512;
    localparam logic [15:0] COOL_MIN     = 16'd1024;
    localparam logic [15:0] COOL_ADD     = 16'd256;
    localparam logic [15:0] RECOV_MIN    = 16'd768;
    localparam logic [15:0] RECOV_ADD    = 16'd205;

    // reset values of the configuration registers
    localparam logic [11:0] RST_MIN_INL_NORM = 12'd15;
    localparam logic [11:0] RST_MIN_INL_REC  = 12'd10;
    localparam logic [10:0] RST_MIN_RAT_NORM = 11'd358;
    localparam logic [10:0] RST_MIN_RAT_REC  = 11'd256;
    localparam logic [15:0] RST_MAX_EPI_NORM = 16'd640;
    localparam logic [15:0] RST_MAX_EPI_REC  = 16'd768;
    localparam logic [15:0] RST_FLIP_LIMIT   = 16'd30720;
    localparam logic [7:0]  RST_COOLDOWN     = 8'd3;

    // saturate a wide limit sum to 16 bits, then apply the lower bound
    function automatic logic [15:0] sat_limit(input logic [19:0] sum,
                                              input logic [15:0] lower);
        logic [15:0] t;
        t = (sum > 20'h0FFFF) ? 16'hFFFF : sum[15:0];
        return (t > lower) ? t : lower;
    endfunction

endpackage

// ===== rtl/motion_step_acceptance_gate.sv =====
// Step acceptance gate: one item is taken while the input side is not stalled
// and gives exactly one result. The recent rotations sit in a ring of
// WINDOW_DEPTH registers with accepted marks; the median of the accepted
// nonzero ones comes from a rank-count unit that looks at one ring entry per
// cycle while the ring rotates once around. After acceptance an item passes
// through the eligible count step, WINDOW_DEPTH rank steps, the median step
// and the decision step, which also writes the step into the ring and loads
// the output register. A result still waiting at the output does not block
// the next item until that item reaches its decision step.
module motion_step_acceptance_gate #(
    parameter int unsigned WINDOW_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [msag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msag_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_in_recovery,
    input  logic [11:0]                         i_in_inlier_count,
    input  logic signed [11:0]                  i_in_inlier_ratio,
    input  logic [15:0]                         i_in_epi_error,
    input  logic [15:0]                         i_in_rotation,
    input  logic [7:0]                          i_in_reject_run,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_out_accepted,
    output logic [2:0]                          o_out_reason,
    output logic [15:0]                         o_out_median_rotation
);

    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_RANK = 3'd2;
    localparam logic [2:0] S_MED  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    logic [2:0]    r_state;
    logic [IW-1:0] r_idx;

    // configuration
    logic [11:0] r_min_inl_norm, r_min_inl_rec;
    logic [10:0] r_min_rat_norm, r_min_rat_rec;
    logic [15:0] r_max_epi_norm, r_max_epi_rec;
    logic [15:0] r_flip_limit;
    logic [7:0]  r_cooldown;

    // latched item
    logic        r_rec;
    logic [11:0] r_count;
    logic [11:0] r_ratio;
    logic [15:0] r_epi;
    logic [15:0] r_rot;
    logic [7:0]  r_run;

    // window ring
    logic [15:0]             r_win [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_acc;

    // median work
    logic [CW-1:0] r_n;
    logic [15:0]   r_lo, r_hi, r_med;

    // output register
    logic                r_out_valid;
    logic                r_out_acc;
    msag_pkg::t_reason   r_out_reason;
    logic [15:0]         r_out_med;

    logic [WINDOW_DEPTH-1:0] elig;
    logic [CW-1:0]           elig_cnt, lt_cnt, le_cnt;
    logic [15:0]             cand;
    logic [CW-1:0]           k_lo, k_hi;
    logic [16:0]             mid_sum;
    logic [15:0]             n_med;
    logic [15:0]             lim_large, lim_cool, lim_recov;
    logic [2:0]              n_reason;
    logic                    in_take, out_free;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cand     = r_win[0];
    assign k_lo     = (r_n - CW'(1)) >> 1;
    assign k_hi     = r_n >> 1;

    // rank lanes: one compare per ring entry against the entry at the ring head
    always_comb begin
        elig_cnt = '0;
        lt_cnt   = '0;
        le_cnt   = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            elig[j]  = r_acc[j] && (r_win[j] != 16'd0);
            elig_cnt = elig_cnt + CW'(elig[j]);
            lt_cnt   = lt_cnt + CW'(elig[j] && (r_win[j] < cand));
            le_cnt   = le_cnt + CW'(elig[j] && (r_win[j] <= cand));
        end
    end

    always_comb begin
        mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
        if (r_n == '0) begin
            n_med = msag_pkg::MED_FALLBACK;
        end else if (r_n[0]) begin
            n_med = r_lo;
        end else begin
            n_med = mid_sum[16:1];
        end
        if (n_med < msag_pkg::MED_FLOOR) begin
            n_med = msag_pkg::MED_FLOOR;
        end
    end

    assign lim_large = msag_pkg::sat_limit({1'b0, r_med, 3'b000} + {4'b0, msag_pkg::LARGE_ADD},
                                           msag_pkg::LARGE_MIN);
    assign lim_cool  = msag_pkg::sat_limit({2'b0, r_med, 2'b00} + {4'b0, msag_pkg::COOL_ADD},
                                           msag_pkg::COOL_MIN);
    assign lim_recov = msag_pkg::sat_limit({4'b0, r_med} + {3'b0, r_med, 1'b0}
                                           + {4'b0, msag_pkg::RECOV_ADD},
                                           msag_pkg::RECOV_MIN);

    // decision cascade, first failing check wins
    always_comb begin
        if (r_count < (r_rec ? r_min_inl_rec : r_min_inl_norm)) begin
            n_reason = msag_pkg::REASON_COUNT;
        end else if (!r_ratio[11] &&
                     (r_ratio < {1'b0, (r_rec ? r_min_rat_rec : r_min_rat_norm)})) begin
            n_reason = msag_pkg::REASON_RATIO;
        end else if (r_epi > (r_rec ? r_max_epi_rec : r_max_epi_norm)) begin
            n_reason = msag_pkg::REASON_EPI;
        end else if (r_rot > r_flip_limit) begin
            n_reason = msag_pkg::REASON_FLIP;
        end else if (!r_rec) begin
            if (r_rot > lim_large) begin
                n_reason = msag_pkg::REASON_LARGE;
            end else if ((r_run >= r_cooldown) && (r_rot > lim_cool)) begin
                n_reason = msag_pkg::REASON_COOLDOWN;
            end else begin
                n_reason = msag_pkg::REASON_OK;
            end
        end else if (r_rot > lim_recov) begin
            n_reason = msag_pkg::REASON_RECOVERY;
        end else begin
            n_reason = msag_pkg::REASON_OK;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_inl_norm <= msag_pkg::RST_MIN_INL_NORM;
            r_min_inl_rec  <= msag_pkg::RST_MIN_INL_REC;
            r_min_rat_norm <= msag_pkg::RST_MIN_RAT_NORM;
            r_min_rat_rec  <= msag_pkg::RST_MIN_RAT_REC;
            r_max_epi_norm <= msag_pkg::RST_MAX_EPI_NORM;
            r_max_epi_rec  <= msag_pkg::RST_MAX_EPI_REC;
            r_flip_limit   <= msag_pkg::RST_FLIP_LIMIT;
            r_cooldown     <= msag_pkg::RST_COOLDOWN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msag_pkg::REG_MIN_INL_NORM: r_min_inl_norm <= i_cfg_data[11:0];
                msag_pkg::REG_MIN_INL_REC:  r_min_inl_rec  <= i_cfg_data[11:0];
                msag_pkg::REG_MIN_RAT_NORM: r_min_rat_norm <= i_cfg_data[10:0];
                msag_pkg::REG_MIN_RAT_REC:  r_min_rat_rec  <= i_cfg_data[10:0];
                msag_pkg::REG_MAX_EPI_NORM: r_max_epi_norm <= i_cfg_data;
                msag_pkg::REG_MAX_EPI_REC:  r_max_epi_rec  <= i_cfg_data;
                msag_pkg::REG_FLIP_LIMIT:   r_flip_limit   <= i_cfg_data;
                msag_pkg::REG_COOLDOWN:     r_cooldown     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DEC) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_idx   <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    // rotate the marks with the ring
                    r_acc <= (r_acc << 1) | (r_acc >> (WINDOW_DEPTH - 1));
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_MED;
                    end
                end
                S_MED: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    // hold until the output register is free, then push the step
                    if (out_free) begin
                        r_acc   <= (r_acc << 1) |
                                   WINDOW_DEPTH'(n_reason == msag_pkg::REASON_OK);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rec   <= i_in_recovery;
            r_count <= i_in_inlier_count;
            r_ratio <= i_in_inlier_ratio;
            r_epi   <= i_in_epi_error;
            r_rot   <= i_in_rotation;
            r_run   <= i_in_reject_run;
        end
        if (r_state == S_CNT) begin
            r_n <= elig_cnt;
        end
        if (r_state == S_RANK) begin
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0] <= r_win[WINDOW_DEPTH-1];
            if (elig[0] && (lt_cnt <= k_lo) && (k_lo < le_cnt)) begin
                r_lo <= cand;
            end
            if (elig[0] && (lt_cnt <= k_hi) && (k_hi < le_cnt)) begin
                r_hi <= cand;
            end
        end
        if (r_state == S_MED) begin
            r_med <= n_med;
        end
        if ((r_state == S_DEC) && out_free) begin
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0]     <= r_rot;
            r_out_acc    <= (n_reason == msag_pkg::REASON_OK);
            r_out_reason <= n_reason;
            r_out_med    <= r_med;
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_out_accepted        = r_out_acc;
    assign o_out_reason          = r_out_reason;
    assign o_out_median_rotation = r_out_med;

    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_CNT))
        else $error("accepted item did not start the eligible count");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK) |-> (r_idx <= LAST_IDX))
        else $error("rank step index past the window");

    a_dec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DEC) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("decision did not load the output register");

    a_med_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_median_rotation >= msag_pkg::MED_FLOOR))
        else $error("median below floor");

    a_acc_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_accepted == (o_out_reason == msag_pkg::REASON_OK)))
        else $error("accept flag and reason disagree");

endmodule
